// ===== rtl/core/rlecd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlecd_pkg
// Shared constants, types and codes of the line edge and colour detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rlecd_pkg;

  localparam int LINE_PIXELS = 640;
  localparam int PIX_W       = 16;
  localparam int SMP_W       = 6;
  localparam int SUM_W       = 16;
  localparam int IDX_W       = 10;
  localparam int ADDR_W      = $clog2(LINE_PIXELS);
  localparam int SLOPE_W     = 7;
  localparam int MINW_W      = 10;
  localparam int MISS_W      = 9;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CLS_W       = 3;
  localparam int OUT_W       = 64;

  localparam logic [IDX_W-1:0] LINE_LEN  = IDX_W'(LINE_PIXELS);
  localparam logic [IDX_W-1:0] LINE_LAST = IDX_W'(LINE_PIXELS - 1);
  localparam logic [IDX_W-1:0] HALF_LINE = IDX_W'(LINE_PIXELS / 2);

  // reciprocal for the final divide by five of the mean
  localparam int MEAN_SHIFT = 7;
  localparam logic [7:0] RECIP_5 = 8'd205;
  localparam int RECIP_SHIFT = 10;

  localparam logic [SLOPE_W-1:0] SLOPE_RST = SLOPE_W'(5);
  localparam logic [MINW_W-1:0]  MINW_RST  = MINW_W'(40);
  localparam logic [MISS_W-1:0]  MISS_RST  = '0;

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_SLOPE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_CORRECTION = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [CLS_W-1:0] CLS_WHITE  = 3'd0;
  localparam logic [CLS_W-1:0] CLS_BLACK  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_GREEN  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_BLUE   = 3'd3;
  localparam logic [CLS_W-1:0] CLS_RED    = 3'd4;
  localparam logic [CLS_W-1:0] CLS_YELLOW = 3'd5;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MEAN,
    ST_SCAN,
    ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_FALL,
    SC_RISE
  } scan_state_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] width;
    logic [IDX_W-1:0] position;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rlecd_ram.sv =====
// ----------------------------------------------------------------------------
// rlecd_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rlecd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 640
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output      logic [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output      logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rlecd_scan.sv =====
// ----------------------------------------------------------------------------
// rlecd_scan
// Edge search over one stored channel: falling then rising edge, narrow
// candidates skipped, one index issued per cycle to the line memory.
// ----------------------------------------------------------------------------
`default_nettype none

module rlecd_scan (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [rlecd_pkg::SLOPE_W-1:0]  slope,
  input  wire logic [rlecd_pkg::MINW_W-1:0]   min_width,
  input  wire logic [rlecd_pkg::MISS_W-1:0]   miss_corr,
  input  wire logic [rlecd_pkg::SMP_W-1:0]    mean,
  output      logic [rlecd_pkg::ADDR_W-1:0]   addr_a,
  output      logic [rlecd_pkg::ADDR_W-1:0]   addr_b,
  input  wire logic [rlecd_pkg::SMP_W-1:0]    smp_a,
  input  wire logic [rlecd_pkg::SMP_W-1:0]    smp_b,
  output      rlecd_pkg::scan_res_t           res
);

  localparam int IW = rlecd_pkg::IDX_W;

  rlecd_pkg::scan_state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] begin_r, begin_nxt;
  rlecd_pkg::scan_res_t res_r, res_nxt;

  logic [IW-1:0] slope_x;
  logic [IW-1:0] lim_f;
  logic [IW-1:0] limit;
  logic          hit;
  logic [IW-1:0] nx_idx;
  logic [IW-1:0] cand_w;
  logic [IW:0]   pos_sum;
  logic [IW-1:0] miss_pos;
  logic [IW-1:0] addr_b_full;

  assign slope_x = IW'(slope);
  assign lim_f   = rlecd_pkg::LINE_LEN - slope_x;
  assign limit   = (state_r == rlecd_pkg::SC_FALL) ? lim_f : rlecd_pkg::LINE_LEN;
  assign hit     = (smp_a > mean) && (smp_b < mean) &&
                   ((state_r == rlecd_pkg::SC_FALL) || (rd_idx_r >= slope_x));
  assign nx_idx  = rd_idx_r + IW'(1);
  assign cand_w  = rd_idx_r - begin_r;
  assign pos_sum = {1'b0, begin_r} + {1'b0, rd_idx_r};
  assign miss_pos = ({1'b0, miss_corr} > rlecd_pkg::HALF_LINE) ? '0 :
                    rlecd_pkg::HALF_LINE - IW'(miss_corr);

  always_comb begin
    if (state_r == rlecd_pkg::SC_FALL) begin
      addr_b_full = idx_r + slope_x;
    end else if (idx_r >= slope_x) begin
      addr_b_full = idx_r - slope_x;
    end else begin
      addr_b_full = '0;
    end
  end

  assign addr_a = idx_r[rlecd_pkg::ADDR_W-1:0];
  assign addr_b = addr_b_full[rlecd_pkg::ADDR_W-1:0];
  assign res    = res_r;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    begin_nxt    = begin_r;
    res_nxt      = res_r;
    res_nxt.done = 1'b0;
    unique case (state_r)
      rlecd_pkg::SC_IDLE: begin
        if (start) begin
          state_nxt = rlecd_pkg::SC_FALL;
          idx_nxt   = '0;
        end
      end
      rlecd_pkg::SC_FALL: begin
        if (rd_vld_r && hit) begin
          begin_nxt = rd_idx_r;
          if ((nx_idx < lim_f) && (rd_idx_r != '0)) begin
            state_nxt = rlecd_pkg::SC_RISE;
            idx_nxt   = nx_idx;
          end else begin
            state_nxt        = rlecd_pkg::SC_IDLE;
            res_nxt.done     = 1'b1;
            res_nxt.width    = '0;
            res_nxt.position = miss_pos;
          end
        end else if (!rd_vld_r && (idx_r >= limit)) begin
          state_nxt        = rlecd_pkg::SC_IDLE;
          res_nxt.done     = 1'b1;
          res_nxt.width    = '0;
          res_nxt.position = miss_pos;
        end else if (idx_r < limit) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt    = idx_r + IW'(1);
        end
      end
      rlecd_pkg::SC_RISE: begin
        if (rd_vld_r && hit) begin
          if (cand_w < min_width) begin
            // narrow candidate, search again from its end
            state_nxt = rlecd_pkg::SC_FALL;
            idx_nxt   = rd_idx_r;
          end else begin
            state_nxt        = rlecd_pkg::SC_IDLE;
            res_nxt.done     = 1'b1;
            res_nxt.width    = cand_w;
            res_nxt.position = pos_sum[IW:1];
          end
        end else if (!rd_vld_r && (idx_r >= limit)) begin
          state_nxt        = rlecd_pkg::SC_IDLE;
          res_nxt.done     = 1'b1;
          res_nxt.width    = '0;
          res_nxt.position = miss_pos;
        end else if (idx_r < limit) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt    = idx_r + IW'(1);
        end
      end
      default: begin
        state_nxt = rlecd_pkg::SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rlecd_pkg::SC_IDLE;
      rd_vld_r <= 1'b0;
      res_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      res_r    <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    rd_idx_r <= rd_idx_nxt;
    begin_r  <= begin_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_line_edge_color_detector.sv =====
// ----------------------------------------------------------------------------
// rgb_line_edge_color_detector
// Stores one RGB565 line, then searches each colour channel for a dark line
// and reports width, centre and a colour class.
// ----------------------------------------------------------------------------
// load: one pixel per cycle while in_tvalid is high, 640 pixels per line into the line memory
// scan: one index per cycle per channel while searching; narrow candidates are
//   skipped, and a falling edge at index zero ends that channel's scan
// sequence: after the last pixel, ST_MEAN loads the means and starts the red scan;
//   the green and blue scans follow in turn, then ST_OUT loads the output register
// throughput: the next line is not accepted until ST_OUT has loaded the result,
//   which waits for out_tready while the previous result is still valid
// reset: synchronous for control and config registers; line memory not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_line_edge_color_detector (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [rlecd_pkg::PIX_W-1:0]       in_tdata,   // pixel
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // red_width, red_position, green_width, green_position, blue_width,
  // blue_position, color_class, zero pad
  output      logic [rlecd_pkg::OUT_W-1:0]       out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [rlecd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rlecd_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int IW = rlecd_pkg::IDX_W;
  localparam int SW = rlecd_pkg::SUM_W;
  localparam int MEAN_SHIFT_C = rlecd_pkg::MEAN_SHIFT;

  rlecd_pkg::top_state_t state_r, state_nxt;

  logic [rlecd_pkg::SLOPE_W-1:0] slope_r;
  logic [rlecd_pkg::MINW_W-1:0]  minw_r;
  logic [rlecd_pkg::MISS_W-1:0]  miss_r;

  logic [IW-1:0] count_r, count_nxt;
  logic [SW-1:0] sums_r [3];
  logic [SW-1:0] sums_nxt [3];
  logic [rlecd_pkg::SMP_W-1:0] mean_r [3];
  logic [1:0]    ch_r, ch_nxt;
  logic [IW-1:0] width_r [3];
  logic [IW-1:0] pos_r [3];

  logic                        out_vld_r, out_vld_nxt;
  logic [rlecd_pkg::OUT_W-1:0] out_data_r;
  logic                        out_load;

  logic in_acc;
  logic scan_start;
  logic mean_load;

  logic [rlecd_pkg::SMP_W-1:0] px_r, px_g, px_b;
  logic [rlecd_pkg::ADDR_W-1:0] addr_a, addr_b;
  logic [rlecd_pkg::PIX_W-1:0]  rdata_a, rdata_b;
  logic [rlecd_pkg::SMP_W-1:0]  smp_a, smp_b;
  rlecd_pkg::scan_res_t         scan_res;
  logic [rlecd_pkg::CLS_W-1:0]  cls;
  logic [SW-MEAN_SHIFT_C-1:0]   mean_q [3];
  logic [SW-1:0]                mean_p [3];

  function automatic logic [rlecd_pkg::SMP_W-1:0] chan_of(
    input logic [rlecd_pkg::PIX_W-1:0] px,
    input logic [1:0]                  ch
  );
    logic [rlecd_pkg::SMP_W-1:0] v;
    unique case (ch)
      rlecd_pkg::CH_RED:   v = {1'b0, px[15:11]};
      rlecd_pkg::CH_GREEN: v = px[10:5];
      default:             v = {1'b0, px[4:0]};
    endcase
    return v;
  endfunction

  assign px_r = chan_of(in_tdata, rlecd_pkg::CH_RED);
  assign px_g = chan_of(in_tdata, rlecd_pkg::CH_GREEN);
  assign px_b = chan_of(in_tdata, rlecd_pkg::CH_BLUE);

  assign in_tready = (state_r == rlecd_pkg::ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;

  rlecd_ram #(
    .WIDTH (rlecd_pkg::PIX_W),
    .DEPTH (rlecd_pkg::LINE_PIXELS)
  ) u_line_mem (
    .clk     (clk),
    .we      (in_acc),
    .waddr   (count_r[rlecd_pkg::ADDR_W-1:0]),
    .wdata   (in_tdata),
    .raddr_a (addr_a),
    .rdata_a (rdata_a),
    .raddr_b (addr_b),
    .rdata_b (rdata_b)
  );

  assign smp_a = chan_of(rdata_a, ch_r);
  assign smp_b = chan_of(rdata_b, ch_r);

  rlecd_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .slope     (slope_r),
    .min_width (minw_r),
    .miss_corr (miss_r),
    .mean      (mean_r[ch_r]),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .smp_a     (smp_a),
    .smp_b     (smp_b),
    .res       (scan_res)
  );

  // sum / 640 as (sum >> 7) / 5 by reciprocal
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mean_q[k] = sums_r[k][SW-1:MEAN_SHIFT_C];
      mean_p[k] = SW'(mean_q[k] * rlecd_pkg::RECIP_5);
    end
  end

  always_comb begin
    if (width_r[0] != '0) begin
      if (width_r[2] != '0) begin
        cls = (width_r[1] != '0) ? rlecd_pkg::CLS_BLACK : rlecd_pkg::CLS_GREEN;
      end else begin
        cls = rlecd_pkg::CLS_BLUE;
      end
    end else if (width_r[1] != '0) begin
      cls = rlecd_pkg::CLS_RED;
    end else if (width_r[2] != '0) begin
      cls = rlecd_pkg::CLS_YELLOW;
    end else begin
      cls = rlecd_pkg::CLS_WHITE;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ch_nxt     = ch_r;
    scan_start = 1'b0;
    mean_load  = 1'b0;
    out_load   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sums_nxt[k] = sums_r[k];
    end
    unique case (state_r)
      rlecd_pkg::ST_LOAD: begin
        if (in_acc) begin
          sums_nxt[0] = sums_r[0] + SW'(px_r);
          sums_nxt[1] = sums_r[1] + SW'(px_g);
          sums_nxt[2] = sums_r[2] + SW'(px_b);
          if (count_r == rlecd_pkg::LINE_LAST) begin
            count_nxt = '0;
            state_nxt = rlecd_pkg::ST_MEAN;
          end else begin
            count_nxt = count_r + IW'(1);
          end
        end
      end
      rlecd_pkg::ST_MEAN: begin
        mean_load  = 1'b1;
        scan_start = 1'b1;
        ch_nxt     = rlecd_pkg::CH_RED;
        state_nxt  = rlecd_pkg::ST_SCAN;
        for (int k = 0; k < 3; k++) begin
          sums_nxt[k] = '0;
        end
      end
      rlecd_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          if (ch_r == rlecd_pkg::CH_BLUE) begin
            state_nxt = rlecd_pkg::ST_OUT;
          end else begin
            ch_nxt     = ch_r + 2'd1;
            scan_start = 1'b1;
          end
        end
      end
      rlecd_pkg::ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = rlecd_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = rlecd_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rlecd_pkg::ST_LOAD;
      count_r   <= '0;
      ch_r      <= rlecd_pkg::CH_RED;
      out_vld_r <= 1'b0;
      slope_r   <= rlecd_pkg::SLOPE_RST;
      minw_r    <= rlecd_pkg::MINW_RST;
      miss_r    <= rlecd_pkg::MISS_RST;
      for (int k = 0; k < 3; k++) begin
        sums_r[k] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ch_r      <= ch_nxt;
      out_vld_r <= out_vld_nxt;
      for (int k = 0; k < 3; k++) begin
        sums_r[k] <= sums_nxt[k];
      end
      if (cfg_we) begin
        unique case (cfg_index)
          rlecd_pkg::REG_EDGE_SLOPE:      slope_r <= cfg_wdata[rlecd_pkg::SLOPE_W-1:0];
          rlecd_pkg::REG_MIN_WIDTH:       minw_r  <= cfg_wdata[rlecd_pkg::MINW_W-1:0];
          rlecd_pkg::REG_MISS_CORRECTION: miss_r  <= cfg_wdata[rlecd_pkg::MISS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mean_load) begin
      for (int k = 0; k < 3; k++) begin
        mean_r[k] <= mean_p[k][rlecd_pkg::RECIP_SHIFT +: rlecd_pkg::SMP_W];
      end
    end
    if ((state_r == rlecd_pkg::ST_SCAN) && scan_res.done) begin
      width_r[ch_r] <= scan_res.width;
      pos_r[ch_r]   <= scan_res.position;
    end
    if (out_load) begin
      out_data_r <= {1'b0, cls, pos_r[2], width_r[2], pos_r[1], width_r[1],
                     pos_r[0], width_r[0]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
